// ----- hdl/branch_predictor_bimodal_top_defines.svh -----
// Assertion macros for the bimodal branch predictor.
// Used by branch_predictor_bimodal_top; expects signals clk and rst_n in scope.
`ifndef BRANCH_PREDICTOR_BIMODAL_TOP_DEFINES_SVH
`define BRANCH_PREDICTOR_BIMODAL_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BPB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bpb_pkg.sv -----
// Package for the bimodal branch predictor: sizes, request and mode codes,
// table entry and statistics types, and the saturating increment.
// No dependencies.
`timescale 1ns / 1ps

package bpb_pkg;

  // Table geometry: indexed by the low PC bits, tagged with the rest.
  localparam int INDEX_BITS  = 10;
  localparam int TAG_BITS    = 32 - INDEX_BITS;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;

  // Stream widths.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_FIELD_W = 98;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Request codes.
  localparam logic [1:0] REQ_PREDICT = 2'd0;
  localparam logic [1:0] REQ_UPDATE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  // Predictor modes.
  localparam logic [1:0] MODE_STATIC_NT = 2'd0;
  localparam logic [1:0] MODE_STATIC_T  = 2'd1;
  localparam logic [1:0] MODE_ONE_BIT   = 2'd2;
  localparam logic [1:0] MODE_TWO_BIT   = 2'd3;

  // Counter values.
  localparam logic [1:0] CTR_STRONG_NT = 2'd0;
  localparam logic [1:0] CTR_WEAK_NT   = 2'd1;
  localparam logic [1:0] CTR_WEAK_T    = 2'd2;
  localparam logic [1:0] CTR_STRONG_T  = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [TAG_BITS-1:0] tag;
    logic [1:0]          ctr;
  } entry_t;

  typedef struct packed {
    logic                  en;
    logic [INDEX_BITS-1:0] idx;
    entry_t                entry;
  } tbl_wr_t;

  typedef struct packed {
    logic [31:0] total;
    logic [31:0] right;
    logic [31:0] wrong;
  } stats_t;

  // Statistic counters hold at all ones.
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ----- hdl/branch_predictor_bimodal_top.sv -----
// Top level of the bimodal branch predictor: handshakes, request register,
// table clearing sweep, statistics and result register.
// Depends on bpb_pkg, bpb_table, bpb_step and the assertion macro header.
//
// Use: requests arrive as beats on the in_ channel (in_tuser carries the
// request code, in_tdata the PC and the taken outcome); every request gives
// exactly one result beat on the out_ channel with the prediction, whether
// it was correct, and the three statistic counters after that request.
// The request register feeds the result register directly. One request is
// taken per cycle while the receiver keeps up and no sweep or clear runs,
// limited by the single read and single write port of the table,
// with entry bypassing between consecutive requests.
// A result waiting on a stalled receiver holds in the output register; the
// request register behind it still takes one more beat, then in_tready drops.
// Reset, a clear request and a cfg_ write of the mode each start a sweep
// that invalidates all 1024 table entries, one entry a cycle, during which
// in_tready is low. Mode writes also zero the statistics.
`timescale 1ns / 1ps
`include "branch_predictor_bimodal_top_defines.svh"

module branch_predictor_bimodal_top
  import bpb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Request channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] branch_pc, [32] taken_outcome, rest 0
  input  logic [1:0]             in_tuser,   // [1:0] req_type
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] predict_taken, [1] was_correct, [33:2] total_count,
  // [65:34] correct_count, [97:66] incorrect_count, rest 0
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Mode register.
  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_wr_data
);

  logic [1:0]            mode_r;
  logic                  s1_valid_r;
  logic [1:0]            s1_req_r;
  logic [31:0]           s1_pc_r;
  logic                  s1_outcome_r;
  logic                  byp_valid_r;
  entry_t                byp_entry_r;
  stats_t                stats_r;
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                  sweep_active_r;
  logic [INDEX_BITS-1:0] sweep_idx_r;

  logic                  s1_adv;
  logic                  s1_clear;
  logic                  in_acc;
  logic                  sweep_last;
  logic [INDEX_BITS-1:0] rd_idx;
  entry_t                rd_entry;
  entry_t                entry_cur;
  tbl_wr_t               step_wr;
  tbl_wr_t               tbl_wr;
  logic                  step_pred;
  logic                  step_correct;
  stats_t                stats_nxt;

  // Handshake: the request register empties into the result register.
  assign s1_adv     = s1_valid_r && (!out_valid_r || out_tready);
  assign s1_clear   = (s1_req_r == REQ_CLEAR);
  assign in_tready  = !sweep_active_r && (!s1_valid_r || (s1_adv && !s1_clear));
  assign in_acc     = in_tvalid && in_tready;
  assign sweep_last = (sweep_idx_r == {INDEX_BITS{1'b1}});
  assign rd_idx     = in_tdata[INDEX_BITS-1:0];

  // Table read is issued as the beat is accepted.
  bpb_table u_table (
    .clk      (clk),
    .rd_en    (in_acc),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .wr       (tbl_wr)
  );

  // Entry written by the previous request to the same index wins over the read.
  assign entry_cur = byp_valid_r ? byp_entry_r : rd_entry;

  bpb_step u_step (
    .mode      (mode_r),
    .req       (s1_req_r),
    .pc        (s1_pc_r),
    .outcome   (s1_outcome_r),
    .entry     (entry_cur),
    .stats     (stats_r),
    .wr        (step_wr),
    .pred      (step_pred),
    .correct   (step_correct),
    .stats_nxt (stats_nxt)
  );

  // Sweep writes take the port; otherwise the advancing request writes.
  always_comb begin
    if (sweep_active_r) begin
      tbl_wr.en    = 1'b1;
      tbl_wr.idx   = sweep_idx_r;
      tbl_wr.entry = '0;
    end else begin
      tbl_wr    = step_wr;
      tbl_wr.en = step_wr.en && s1_adv;
    end
  end

  // Mode register and statistics.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_STATIC_NT;
      stats_r <= '0;
    end else if (cfg_wr_en) begin
      mode_r  <= cfg_wr_data;
      stats_r <= '0;
    end else if (s1_adv) begin
      stats_r <= stats_nxt;
    end
  end

  // Clearing sweep over the whole table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_active_r <= 1'b1;
      sweep_idx_r    <= '0;
    end else if (cfg_wr_en || (s1_adv && s1_clear)) begin
      sweep_active_r <= 1'b1;
      sweep_idx_r    <= '0;
    end else if (sweep_active_r) begin
      sweep_active_r <= !sweep_last;
      sweep_idx_r    <= sweep_idx_r + 1'b1;
    end
  end

  // Request register and bypass capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      byp_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r  <= 1'b1;
      byp_valid_r <= s1_adv && step_wr.en && (step_wr.idx == rd_idx);
    end else if (s1_adv) begin
      s1_valid_r  <= 1'b0;
      byp_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r     <= in_tuser;
      s1_pc_r      <= in_tdata[31:0];
      s1_outcome_r <= in_tdata[32];
      byp_entry_r  <= step_wr.entry;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, stats_nxt.wrong, stats_nxt.right,
                     stats_nxt.total, step_correct, step_pred};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks.
  `BPB_ASSERT_SAME(a_sweep_blocks_input, sweep_active_r, !in_tready,
                   "request accepted during table sweep")
  `BPB_ASSERT_SAME(a_clear_blocks_input, s1_valid_r && s1_clear, !in_tready,
                   "request accepted behind a clear")
  `BPB_ASSERT_NEXT(a_sweep_runs_out, sweep_active_r && !sweep_last, sweep_active_r,
                   "table sweep ended early")
  `BPB_ASSERT_NEXT(a_result_follows, s1_adv, out_tvalid,
                   "advanced request produced no result beat")

endmodule

// ----- hdl/bpb_table.sv -----
// History table of the bimodal predictor: one write port, one registered read.
// Depends on bpb_pkg.
`timescale 1ns / 1ps

module bpb_table
  import bpb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [INDEX_BITS-1:0] rd_idx,
  output entry_t                rd_entry,
  input  tbl_wr_t               wr
);

  entry_t tbl_mem_r [TABLE_DEPTH];
  entry_t rd_entry_r;

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      tbl_mem_r[wr.idx] <= wr.entry;
    end
    if (rd_en) begin
      rd_entry_r <= tbl_mem_r[rd_idx];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

// ----- hdl/bpb_step.sv -----
// Per-request logic of the bimodal predictor: prediction, entry update and
// statistics for one request. Purely combinational. Depends on bpb_pkg.
`timescale 1ns / 1ps

module bpb_step
  import bpb_pkg::*;
(
  input  logic [1:0]  mode,
  input  logic [1:0]  req,
  input  logic [31:0] pc,
  input  logic        outcome,
  input  entry_t      entry,
  input  stats_t      stats,
  output tbl_wr_t     wr,
  output logic        pred,
  output logic        correct,
  output stats_t      stats_nxt
);

  always_comb begin
    logic [TAG_BITS-1:0] tag;
    logic                hit;
    logic [1:0]          ctr;

    tag = pc[31:INDEX_BITS];
    hit = entry.valid && (entry.tag == tag);
    ctr = entry.ctr;

    wr.en          = 1'b0;
    wr.idx         = pc[INDEX_BITS-1:0];
    wr.entry.valid = 1'b1;
    wr.entry.tag   = tag;
    wr.entry.ctr   = entry.ctr;
    pred           = 1'b0;
    correct        = 1'b0;
    stats_nxt      = stats;

    unique case (req)
      REQ_PREDICT: begin
        stats_nxt.total = sat_inc(stats.total);
        if (mode == MODE_STATIC_T) begin
          pred = 1'b1;
        end else if (mode == MODE_ONE_BIT || mode == MODE_TWO_BIT) begin
          // A miss installs a fresh not-taken entry.
          if (!hit) begin
            ctr = (mode == MODE_ONE_BIT) ? CTR_STRONG_NT : CTR_WEAK_NT;
          end
          wr.en        = !hit;
          wr.entry.ctr = ctr;
          pred         = (mode == MODE_ONE_BIT) ? (ctr != CTR_STRONG_NT) : ctr[1];
        end
      end
      REQ_UPDATE: begin
        unique case (mode)
          MODE_STATIC_NT: pred = 1'b0;
          MODE_STATIC_T:  pred = 1'b1;
          MODE_ONE_BIT: begin
            pred         = hit && (entry.ctr != CTR_STRONG_NT);
            wr.en        = 1'b1;
            wr.entry.ctr = {1'b0, outcome};
          end
          MODE_TWO_BIT: begin
            if (hit) begin
              // Step the counter towards the outcome, saturating at both ends.
              pred = entry.ctr[1];
              if (outcome) begin
                ctr = (entry.ctr == CTR_STRONG_T) ? entry.ctr : entry.ctr + 2'd1;
              end else begin
                ctr = (entry.ctr == CTR_STRONG_NT) ? entry.ctr : entry.ctr - 2'd1;
              end
            end else begin
              pred = 1'b0;
              ctr  = outcome ? CTR_WEAK_T : CTR_WEAK_NT;
            end
            wr.en        = 1'b1;
            wr.entry.ctr = ctr;
          end
          default: pred = 1'b0;
        endcase
        correct = (pred == outcome);
        if (correct) begin
          stats_nxt.right = sat_inc(stats.right);
        end else begin
          stats_nxt.wrong = sat_inc(stats.wrong);
        end
      end
      REQ_CLEAR: begin
        stats_nxt = '0;
      end
      default: begin
        stats_nxt = stats;
      end
    endcase
  end

endmodule
